// ===== src/igcd_pkg.sv =====
`timescale 1ns / 1ps

package igcd_pkg;

    localparam int PIX_W  = 16;
    localparam int DIFF_W = 17;
    localparam int GRAD_W = 18;
    localparam int COL_W  = 12;
    localparam int ROW_W  = 16;
    localparam int IMGW_W = 13;
    localparam int IMGH_W = 16;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IMGW_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [IMGH_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

    // Result slots released by one pixel, in delivery order
    localparam logic [2:0] PICK_CUR    = 3'b001;  // pixel above, row y-1
    localparam logic [2:0] PICK_LEFT   = 3'b010;  // left neighbour on the last row
    localparam logic [2:0] PICK_CORNER = 3'b100;  // bottom right corner

    typedef logic signed [PIX_W-1:0]  t_pix;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [GRAD_W-1:0] t_grad;

    typedef struct packed {
        t_pix               pix;
        t_pix               prev;
        t_pix               prev2;
        t_pix               left;
        t_pix               c;
        t_pix               right;
        t_pix               up;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               col0;
        logic               col1;
        logic               lastcol;
        logic               row1;
    } t_stage;

    typedef struct packed {
        t_grad              gx;
        t_grad              gy;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last;
    } t_result;

    function automatic t_diff diff(input t_pix a, input t_pix b);
        t_diff ea;
        t_diff eb;
        ea = {a[PIX_W-1], a};
        eb = {b[PIX_W-1], b};
        return ea - eb;
    endfunction

    function automatic t_grad dbl(input t_diff d);
        return {d, 1'b0};
    endfunction

    function automatic t_grad sext(input t_diff d);
        return {d[DIFF_W-1], d};
    endfunction

endpackage

// ===== src/igcd_ram.sv =====
`timescale 1ns / 1ps

module igcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== src/igcd_pick.sv =====
`timescale 1ns / 1ps

module igcd_pick (
    input  igcd_pkg::t_stage  i_stage,
    input  logic [2:0]        i_mask,
    output logic [2:0]        o_pick,
    output igcd_pkg::t_result o_result
);

    // Lowest pending slot goes first
    assign o_pick = i_mask & (~i_mask + 3'd1);

    always_comb begin
        o_result = '0;
        case (o_pick)
            igcd_pkg::PICK_CUR: begin
                if (i_stage.col0) begin
                    o_result.gx = igcd_pkg::dbl(igcd_pkg::diff(i_stage.right, i_stage.c));
                end else if (i_stage.lastcol) begin
                    o_result.gx = igcd_pkg::dbl(igcd_pkg::diff(i_stage.c, i_stage.left));
                end else begin
                    o_result.gx = igcd_pkg::sext(igcd_pkg::diff(i_stage.right, i_stage.left));
                end
                if (i_stage.row1) begin
                    o_result.gy = igcd_pkg::dbl(igcd_pkg::diff(i_stage.c, i_stage.pix));
                end else begin
                    o_result.gy = igcd_pkg::sext(igcd_pkg::diff(i_stage.up, i_stage.pix));
                end
                o_result.col  = i_stage.col;
                o_result.row  = i_stage.row - igcd_pkg::ROW_W'(1);
                o_result.last = 1'b0;
            end
            igcd_pkg::PICK_LEFT: begin
                if (i_stage.col1) begin
                    o_result.gx = igcd_pkg::dbl(igcd_pkg::diff(i_stage.pix, i_stage.prev));
                end else begin
                    o_result.gx = igcd_pkg::sext(igcd_pkg::diff(i_stage.pix, i_stage.prev2));
                end
                o_result.gy   = igcd_pkg::dbl(igcd_pkg::diff(i_stage.left, i_stage.prev));
                o_result.col  = i_stage.col - igcd_pkg::COL_W'(1);
                o_result.row  = i_stage.row;
                o_result.last = 1'b0;
            end
            igcd_pkg::PICK_CORNER: begin
                o_result.gx   = igcd_pkg::dbl(igcd_pkg::diff(i_stage.pix, i_stage.prev));
                o_result.gy   = igcd_pkg::dbl(igcd_pkg::diff(i_stage.c, i_stage.pix));
                o_result.col  = i_stage.col;
                o_result.row  = i_stage.row;
                o_result.last = 1'b1;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

// ===== src/image_gradient_central_diff_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// pixel     in         i_valid / o_ready     i_pixel_value
// gradient  out        o_valid / i_ready     o_grad_x, o_grad_y, o_out_col, o_out_row,
//                                            o_frame_last
// config    in (APB)   psel, penable, pwrite paddr, pwdata, prdata (pready tied high)
//
// One pixel per clock in steady state; each result passes the line buffer read, then the
// output register. On the last row a pixel past column 0 releases two results and the
// last pixel three, so the input channel holds ready low there: the single output
// register is the limit. Reset is synchronous, active low, clears control state and
// loads the default frame size; the line buffers are not cleared. A stall on the output
// holds the pending transaction and backs up the input.

module image_gradient_central_diff_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [igcd_pkg::PIX_W-1:0] i_pixel_value,

    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [igcd_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [igcd_pkg::GRAD_W-1:0] o_grad_y,
    output logic [igcd_pkg::COL_W-1:0]        o_out_col,
    output logic [igcd_pkg::ROW_W-1:0]        o_out_row,
    output logic                              o_frame_last,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [igcd_pkg::APB_AW-1:0]       paddr,
    input  logic [igcd_pkg::APB_DW-1:0]       pwdata,
    output logic [igcd_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    // Column index width, and a compare width that holds both MAX_WIDTH and the register
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (AW + 1 > igcd_pkg::IMGW_W) ? AW + 1 : igcd_pkg::IMGW_W;

    // ---------------------------------------------------------------- configuration
    logic [igcd_pkg::IMGW_W-1:0] r_img_w;
    logic [igcd_pkg::IMGH_W-1:0] r_img_h;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[2])
            igcd_pkg::REG_IMAGE_WIDTH: begin
                prdata = igcd_pkg::APB_DW'(r_img_w);
            end
            igcd_pkg::REG_IMAGE_HEIGHT: begin
                prdata = igcd_pkg::APB_DW'(r_img_h);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= igcd_pkg::IMAGE_WIDTH_RST;
            r_img_h <= igcd_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == igcd_pkg::REG_IMAGE_WIDTH) begin
                r_img_w <= pwdata[igcd_pkg::IMGW_W-1:0];
            end else begin
                r_img_h <= pwdata[igcd_pkg::IMGH_W-1:0];
            end
        end
    end

    // Clamp the frame size into its working range
    logic [LW-1:0]               w_ext;
    logic [LW-1:0]               w_eff;
    logic [igcd_pkg::IMGH_W-1:0] h_eff;

    always_comb begin
        w_ext = LW'(r_img_w);
        if (w_ext < LW'(2)) begin
            w_eff = LW'(2);
        end else if (w_ext > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff = (r_img_h < igcd_pkg::IMGH_W'(2)) ? igcd_pkg::IMGH_W'(2) : r_img_h;
    end

    // ---------------------------------------------------------------- raster position
    logic [AW-1:0]              r_col;
    logic [igcd_pkg::ROW_W-1:0] r_row;
    logic                       r_bank;     // which buffer holds the previous row
    logic [AW-1:0]              col_inc;
    logic                       at_lastcol;
    logic                       at_lastrow;
    logic                       accept;

    assign accept     = i_valid & o_ready;
    assign col_inc    = r_col + AW'(1);
    assign at_lastcol = (LW'(r_col) >= w_eff - LW'(1));
    assign at_lastrow = (r_row >= h_eff - igcd_pkg::ROW_W'(1));

    // Any register write restarts the frame; line buffers keep their contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= 1'b0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (at_lastcol) begin
                // Swap roles: the row just written becomes the previous row
                r_col  <= '0;
                r_row  <= at_lastrow ? '0 : r_row + igcd_pkg::ROW_W'(1);
                r_bank <= ~r_bank;
            end else begin
                r_col <= col_inc;
            end
        end
    end

    // ---------------------------------------------------------------- line buffers
    // Port A reads column x of both buffers (centre and above), port B reads x+1.
    // The current pixel goes into the buffer that holds row y-2.
    logic [igcd_pkg::PIX_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

    igcd_ram #(
        .WIDTH (igcd_pkg::PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line0 (
        .i_clk     (i_clk),
        .i_we      (accept & r_bank),
        .i_waddr   (r_col),
        .i_wdata   (i_pixel_value),
        .i_re      (accept),
        .i_raddr_a (r_col),
        .i_raddr_b (col_inc),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    igcd_ram #(
        .WIDTH (igcd_pkg::PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line1 (
        .i_clk     (i_clk),
        .i_we      (accept & ~r_bank),
        .i_waddr   (r_col),
        .i_wdata   (i_pixel_value),
        .i_re      (accept),
        .i_raddr_a (r_col),
        .i_raddr_b (col_inc),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    // ---------------------------------------------------------------- working stage
    // Holds the last accepted pixel until every result it releases has moved on.
    igcd_pkg::t_pix             r_pix, r_prev, r_prev2, r_left;
    logic                       r_s1_bank;
    logic [igcd_pkg::COL_W-1:0] r_s1_col;
    logic [igcd_pkg::ROW_W-1:0] r_s1_row;
    logic                       r_s1_col0, r_s1_col1, r_s1_lastcol, r_s1_row1;
    logic [2:0]                 r_mask;
    logic [2:0]                 n_mask;

    igcd_pkg::t_pix     cur_c;
    igcd_pkg::t_pix     cur_right;
    igcd_pkg::t_pix     cur_up;
    igcd_pkg::t_stage   stage;
    igcd_pkg::t_result  result;
    logic [2:0]         pick;
    logic               busy;
    logic               single;
    logic               out_free;
    logic               move;

    assign cur_c     = r_s1_bank ? rd1_a : rd0_a;
    assign cur_right = r_s1_bank ? rd1_b : rd0_b;
    assign cur_up    = r_s1_bank ? rd0_a : rd1_a;

    always_comb begin
        stage.pix     = r_pix;
        stage.prev    = r_prev;
        stage.prev2   = r_prev2;
        stage.left    = r_left;
        stage.c       = cur_c;
        stage.right   = cur_right;
        stage.up      = cur_up;
        stage.col     = r_s1_col;
        stage.row     = r_s1_row;
        stage.col0    = r_s1_col0;
        stage.col1    = r_s1_col1;
        stage.lastcol = r_s1_lastcol;
        stage.row1    = r_s1_row1;
    end

    igcd_pick u_pick (
        .i_stage  (stage),
        .i_mask   (r_mask),
        .o_pick   (pick),
        .o_result (result)
    );

    assign busy     = |r_mask;
    assign single   = ((r_mask & (r_mask - 3'd1)) == 3'd0);
    assign out_free = ~o_valid | i_ready;
    assign move     = busy & out_free;
    // Take a new pixel once the stage is empty or gives up its final result now
    assign o_ready  = ~busy | (move & single);

    always_comb begin
        n_mask = r_mask;
        if (accept) begin
            n_mask[0] = (r_row != '0);
            n_mask[1] = at_lastrow & (r_col != '0);
            n_mask[2] = at_lastrow & at_lastcol;
        end else if (move) begin
            n_mask = r_mask & ~pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    // Pixel history and window shift advance on acceptance only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix        <= i_pixel_value;
            r_prev       <= r_pix;
            r_prev2      <= r_prev;
            r_left       <= cur_c;
            r_s1_bank    <= r_bank;
            r_s1_col     <= igcd_pkg::COL_W'(r_col);
            r_s1_row     <= r_row;
            r_s1_col0    <= (r_col == '0);
            r_s1_col1    <= (r_col == AW'(1));
            r_s1_lastcol <= at_lastcol;
            r_s1_row1    <= (r_row == igcd_pkg::ROW_W'(1));
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (move) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            o_grad_x     <= result.gx;
            o_grad_y     <= result.gy;
            o_out_col    <= result.col;
            o_out_row    <= result.row;
            o_frame_last <= result.last;
        end
    end

endmodule
